/* rtl/sle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the scancode line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CUR_W  = 6;
	localparam int LEN_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CODE_W = 8;
	localparam int KIDX_W = 7;
	localparam int HOLD_W = 5;
	localparam int RD_W   = 5;

	localparam logic [CODE_W-1:0] CODE_ESC     = 8'd1;
	localparam logic [CODE_W-1:0] CODE_BACK    = 8'd14;
	localparam logic [CODE_W-1:0] CODE_ENTER   = 8'd28;
	localparam logic [CODE_W-1:0] CODE_LSHIFT  = 8'd42;
	localparam logic [CODE_W-1:0] CODE_RSHIFT  = 8'd54;
	localparam logic [CODE_W-1:0] CODE_MAPMAX  = 8'd57;
	localparam logic [CODE_W-1:0] CODE_LEFT    = 8'd75;
	localparam logic [CODE_W-1:0] CODE_RIGHT   = 8'd77;
	localparam logic [CODE_W-1:0] CODE_DEL     = 8'd83;
	localparam logic [CODE_W-1:0] CODE_RESEND  = 8'd224;
	localparam logic [CODE_W-1:0] CODE_RELEASE = 8'd128;
	localparam logic [CODE_W-1:0] CODE_LSHIFT_UP = CODE_LSHIFT + CODE_RELEASE;
	localparam logic [CODE_W-1:0] CODE_RSHIFT_UP = CODE_RSHIFT + CODE_RELEASE;

	localparam logic [HOLD_W-1:0] HOLD_TOP     = 5'd16;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [RD_W-1:0]   REPEAT_RESET = 5'd15;

	localparam int REG_ADDR_W = 3;
	localparam logic REG_IDX_REPEAT = 1'b0;

	typedef enum logic [3:0] {
		K_IGNORE  = 4'd0,
		K_INSERT  = 4'd1,
		K_LEFT    = 4'd2,
		K_RIGHT   = 4'd3,
		K_BACK    = 4'd4,
		K_DELETE  = 4'd5,
		K_FULL    = 4'd6,
		K_LINECH  = 4'd7,
		K_EMPTY   = 4'd8,
		K_MAPWR   = 4'd9
	} kind_t;

	typedef enum logic [3:0] {
		A_MAP, A_NONE, A_SHIFT_ON, A_SHIFT_OFF, A_LEFT, A_RIGHT,
		A_BACK, A_DEL, A_ESC, A_ENTER, A_KEY
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_KMAP, ST_INS, ST_INS_WR, ST_REM, ST_EMIT, ST_NL, ST_RESULT
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_value;
		logic [CUR_W-1:0]  cursor;
		logic [LEN_W-1:0]  line_length;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [KIDX_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [KIDX_W-1:0] raddr;
	} km_req_t;

	typedef struct packed {
		logic              we;
		logic [CUR_W-1:0]  waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [CUR_W-1:0]  raddr;
	} tx_req_t;

endpackage

/* rtl/sle_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_if
// Request and result channels of the line editor.
// ----------------------------------------------------------------------------
interface sle_req_if
	import sle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [KIDX_W-1:0] map_index;
	logic [CHAR_W-1:0] map_char;
	logic [CODE_W-1:0] scancode;

	modport source (output valid, req_type, map_index, map_char, scancode, input ready);
	modport sink (input valid, req_type, map_index, map_char, scancode, output ready);
endinterface

interface sle_rsp_if
	import sle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [3:0]        kind;
	logic [CHAR_W-1:0] char_value;
	logic [CUR_W-1:0]  cursor;
	logic [LEN_W-1:0]  line_length;
	logic              last;

	modport source (output valid, kind, char_value, cursor, line_length, last, input ready);
	modport sink (input valid, kind, char_value, cursor, line_length, last, output ready);
endinterface

/* rtl/sle_keymap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_keymap
// Keymap memory, one write and one registered read per cycle; entries never
// written read as zero.
// ----------------------------------------------------------------------------
module sle_keymap
	import sle_pkg::*;
#(
	parameter int KEYMAP_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  km_req_t           req,
	output logic [CHAR_W-1:0] rdata
);
	localparam int KW = $clog2(KEYMAP_DEPTH);

	logic [CHAR_W-1:0]       mem [KEYMAP_DEPTH];
	logic [KEYMAP_DEPTH-1:0] valid_q;
	logic [CHAR_W-1:0]       rdata_q;
	logic                    rvalid_q;
	logic                    wr_ok;
	logic                    rd_ok;

	assign wr_ok = req.we && (int'(req.waddr) < KEYMAP_DEPTH);
	assign rd_ok = req.re && (int'(req.raddr) < KEYMAP_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[req.waddr[KW-1:0]] <= req.wdata;
		end
		if (rd_ok) begin
			rdata_q <= mem[req.raddr[KW-1:0]];
		end
	end

	// entries beyond the depth read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[req.waddr[KW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= rd_ok && valid_q[req.raddr[KW-1:0]];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;
endmodule

/* rtl/sle_text_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_text_ram
// Edit line storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sle_text_ram
	import sle_pkg::*;
#(
	parameter int TEXT_MAX = 63
) (
	input  logic              clk,
	input  tx_req_t           req,
	output logic [CHAR_W-1:0] rdata
);
	localparam int AW = $clog2(TEXT_MAX);

	logic [CHAR_W-1:0] mem [TEXT_MAX];
	logic [CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/sle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Poll decode, edit sequencer over the line memory, and result register.
// ----------------------------------------------------------------------------
module sle_ctrl
	import sle_pkg::*;
#(
	parameter int TEXT_MAX = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RD_W-1:0]   repeat_delay,
	sle_req_if.sink           req,
	sle_rsp_if.source         rsp,
	output km_req_t           km_req,
	input  logic [CHAR_W-1:0] km_rdata,
	output tx_req_t           tx_req,
	input  logic [CHAR_W-1:0] tx_rdata
);
	state_t state_q, state_d;

	logic [CODE_W-1:0] last_good_q, last_good_d;
	logic [CODE_W-1:0] prev_q, prev_d;
	logic [HOLD_W-1:0] hold_q, hold_d;
	logic              shift_q, shift_d;
	logic [CUR_W-1:0]  len_q, len_d;
	logic [CUR_W-1:0]  cur_q, cur_d;
	logic [CUR_W-1:0]  ptr_q, ptr_d;
	logic [CHAR_W-1:0] ch_q, ch_d;
	kind_t             kind_q, kind_d;
	logic              nl_q, nl_d;
	res_t              res_q, res_d;
	logic              ovalid_q;
	res_t              ores_q;

	logic              can_push, acc, push;
	res_t              push_res;
	logic [CODE_W-1:0] sc;
	logic              resend;
	logic [HOLD_W-1:0] hold_n;
	logic              act;
	action_t           action;
	logic [CUR_W-1:0]  rem_cur;
	logic              rem_move;
	logic [LEN_W-1:0]  total;
	logic              ptr_at_len;

	assign can_push = !ovalid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && can_push;
	assign acc = req.valid && req.ready;
	assign total = {1'b0, len_q} + LEN_W'(nl_q);
	assign ptr_at_len = ({1'b0, ptr_q} + 7'd1) == {1'b0, len_q};

	// poll decode
	always_comb begin
		resend = (req.scancode == CODE_RESEND) || (req.scancode == '0);
		sc = resend ? last_good_q : req.scancode;
		if (sc != prev_q) begin
			hold_n = '0;
		end else if (hold_q >= HOLD_TOP) begin
			hold_n = HOLD_TOP - 5'd1;
		end else begin
			hold_n = hold_q + 5'd1;
		end
		act = !(hold_n[0] || (hold_n != '0 && hold_n < repeat_delay));
		rem_cur = (sc == CODE_BACK) ? cur_q - 6'd1 : cur_q;
		rem_move = ({1'b0, rem_cur} + 7'd1) < {1'b0, len_q};
		priority if (!req.req_type) begin
			action = A_MAP;
		end else if (sc == CODE_ENTER) begin
			action = A_ENTER;
		end else if (!act) begin
			action = A_NONE;
		end else if (sc == CODE_LSHIFT || sc == CODE_RSHIFT) begin
			action = A_SHIFT_ON;
		end else if (sc == CODE_LSHIFT_UP || sc == CODE_RSHIFT_UP) begin
			action = A_SHIFT_OFF;
		end else if (sc == CODE_LEFT) begin
			action = (cur_q == '0) ? A_NONE : A_LEFT;
		end else if (sc == CODE_RIGHT) begin
			action = (cur_q >= len_q) ? A_NONE : A_RIGHT;
		end else if (sc == CODE_BACK) begin
			action = (cur_q == '0) ? A_NONE : A_BACK;
		end else if (sc == CODE_DEL) begin
			action = (cur_q >= len_q) ? A_NONE : A_DEL;
		end else if (sc == CODE_ESC) begin
			action = A_ESC;
		end else if (sc <= CODE_MAPMAX) begin
			action = A_KEY;
		end else begin
			action = A_NONE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (action)
						A_KEY: state_d = ST_KMAP;
						A_BACK, A_DEL: state_d = rem_move ? ST_REM : ST_IDLE;
						A_ESC, A_ENTER: state_d = (len_q != '0) ? ST_EMIT : ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_KMAP: begin
				if (km_rdata == '0 || int'(len_q) >= TEXT_MAX) begin
					state_d = ST_RESULT;
				end else begin
					state_d = (len_q != cur_q) ? ST_INS : ST_INS_WR;
				end
			end
			ST_INS: if (ptr_q == cur_q) state_d = ST_INS_WR;
			ST_INS_WR: state_d = ST_RESULT;
			ST_REM: if (ptr_at_len) state_d = ST_RESULT;
			ST_EMIT: begin
				if (can_push && ptr_at_len) begin
					state_d = nl_q ? ST_NL : ST_IDLE;
				end
			end
			ST_NL: if (can_push) state_d = ST_IDLE;
			ST_RESULT: if (can_push) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and memory requests
	always_comb begin
		last_good_d = last_good_q;
		prev_d = prev_q;
		hold_d = hold_q;
		shift_d = shift_q;
		len_d = len_q;
		cur_d = cur_q;
		ptr_d = ptr_q;
		ch_d = ch_q;
		kind_d = kind_q;
		nl_d = nl_q;
		res_d = res_q;
		km_req = '0;
		tx_req = '0;
		push = 1'b0;
		push_res = '{kind: K_IGNORE, char_value: '0, cursor: cur_q,
			line_length: {1'b0, len_q}, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (action != A_MAP) begin
						last_good_d = resend ? last_good_q : req.scancode;
						prev_d = sc;
						hold_d = hold_n;
					end
					unique case (action)
						A_MAP: begin
							km_req.we = 1'b1;
							km_req.waddr = req.map_index;
							km_req.wdata = req.map_char;
							push = 1'b1;
							push_res.kind = K_MAPWR;
							push_res.char_value = req.map_char;
						end
						A_NONE: push = 1'b1;
						A_SHIFT_ON: begin
							shift_d = 1'b1;
							push = 1'b1;
						end
						A_SHIFT_OFF: begin
							shift_d = 1'b0;
							push = 1'b1;
						end
						A_LEFT: begin
							cur_d = cur_q - 6'd1;
							push = 1'b1;
							push_res.kind = K_LEFT;
							push_res.cursor = cur_d;
						end
						A_RIGHT: begin
							cur_d = cur_q + 6'd1;
							push = 1'b1;
							push_res.kind = K_RIGHT;
							push_res.cursor = cur_d;
						end
						A_BACK, A_DEL: begin
							cur_d = rem_cur;
							kind_d = (action == A_BACK) ? K_BACK : K_DELETE;
							if (rem_move) begin
								tx_req.re = 1'b1;
								tx_req.raddr = rem_cur + 6'd1;
								ptr_d = rem_cur + 6'd1;
							end else begin
								len_d = len_q - 6'd1;
								push = 1'b1;
								push_res.kind = kind_d;
								push_res.cursor = rem_cur;
								push_res.line_length = {1'b0, len_d};
							end
						end
						A_ESC, A_ENTER: begin
							last_good_d = '0;
							prev_d = '0;
							hold_d = '0;
							shift_d = 1'b0;
							nl_d = (action == A_ENTER);
							if (len_q != '0) begin
								tx_req.re = 1'b1;
								tx_req.raddr = '0;
								ptr_d = '0;
							end else begin
								push = 1'b1;
								push_res.cursor = '0;
								if (action == A_ENTER) begin
									push_res.kind = K_LINECH;
									push_res.char_value = CHAR_NEWLINE;
									push_res.line_length = 7'd1;
								end else begin
									push_res.kind = K_EMPTY;
									push_res.line_length = '0;
								end
							end
						end
						A_KEY: begin
							km_req.re = 1'b1;
							km_req.raddr = {sc[KIDX_W-2:0], shift_q};
						end
						default: ;
					endcase
				end
			end
			ST_KMAP: begin
				res_d = '{kind: K_IGNORE, char_value: '0, cursor: cur_q,
					line_length: {1'b0, len_q}, last: 1'b1};
				if (km_rdata == '0) begin
					res_d.kind = K_IGNORE;
				end else if (int'(len_q) >= TEXT_MAX) begin
					res_d.kind = K_FULL;
					res_d.char_value = km_rdata;
				end else begin
					ch_d = km_rdata;
					if (len_q != cur_q) begin
						tx_req.re = 1'b1;
						tx_req.raddr = len_q - 6'd1;
						ptr_d = len_q - 6'd1;
					end
				end
			end
			ST_INS: begin
				// shift right: write the entry read last cycle one place up
				tx_req.we = 1'b1;
				tx_req.waddr = ptr_q + 6'd1;
				tx_req.wdata = tx_rdata;
				if (ptr_q != cur_q) begin
					tx_req.re = 1'b1;
					tx_req.raddr = ptr_q - 6'd1;
					ptr_d = ptr_q - 6'd1;
				end
			end
			ST_INS_WR: begin
				tx_req.we = 1'b1;
				tx_req.waddr = cur_q;
				tx_req.wdata = ch_q;
				cur_d = cur_q + 6'd1;
				len_d = len_q + 6'd1;
				res_d = '{kind: K_INSERT, char_value: ch_q, cursor: cur_d,
					line_length: {1'b0, len_d}, last: 1'b1};
			end
			ST_REM: begin
				// shift left: write the entry read last cycle one place down
				tx_req.we = 1'b1;
				tx_req.waddr = ptr_q - 6'd1;
				tx_req.wdata = tx_rdata;
				if (ptr_at_len) begin
					len_d = len_q - 6'd1;
					res_d = '{kind: kind_q, char_value: '0, cursor: cur_q,
						line_length: {1'b0, len_d}, last: 1'b1};
				end else begin
					tx_req.re = 1'b1;
					tx_req.raddr = ptr_q + 6'd1;
					ptr_d = ptr_q + 6'd1;
				end
			end
			ST_EMIT: begin
				if (can_push) begin
					push = 1'b1;
					push_res = '{kind: K_LINECH, char_value: tx_rdata, cursor: '0,
						line_length: total,
						last: ({1'b0, ptr_q} + 7'd1) == total};
					if (ptr_at_len) begin
						if (!nl_q) begin
							len_d = '0;
							cur_d = '0;
						end
					end else begin
						tx_req.re = 1'b1;
						tx_req.raddr = ptr_q + 6'd1;
						ptr_d = ptr_q + 6'd1;
					end
				end
			end
			ST_NL: begin
				if (can_push) begin
					push = 1'b1;
					push_res = '{kind: K_LINECH, char_value: CHAR_NEWLINE, cursor: '0,
						line_length: total, last: 1'b1};
					len_d = '0;
					cur_d = '0;
				end
			end
			ST_RESULT: begin
				if (can_push) begin
					push = 1'b1;
					push_res = res_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_good_q <= '0;
			prev_q <= '0;
			hold_q <= '0;
			shift_q <= 1'b0;
			len_q <= '0;
			cur_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_good_q <= last_good_d;
			prev_q <= prev_d;
			hold_q <= hold_d;
			shift_q <= shift_d;
			len_q <= len_d;
			cur_q <= cur_d;
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		ch_q <= ch_d;
		kind_q <= kind_d;
		nl_q <= nl_d;
		res_q <= res_d;
		if (push) begin
			ores_q <= push_res;
		end
	end

	assign rsp.valid = ovalid_q;
	assign rsp.kind = ores_q.kind;
	assign rsp.char_value = ores_q.char_value;
	assign rsp.cursor = ores_q.cursor;
	assign rsp.line_length = ores_q.line_length;
	assign rsp.last = ores_q.last;
endmodule

/* rtl/scancode_line_editor_unit.sv */
`timescale 1ns / 1ps
// Keymap writes and simple polls present their result in the cycle after accept.
// Key insert: keymap read, shift-right walk, insert write and result states.
// Backspace/delete: shift-left walk, result. Line out: one char per cycle unless
// the result channel stalls, newline after. New requests are taken only in idle.
// Reset clears edit state, keymap valid bits and sets repeat_delay to 15;
// line storage is not cleared.
// ----------------------------------------------------------------------------
// scancode_line_editor_unit
// Keyboard poll line editor with APB register port for the repeat delay.
// ----------------------------------------------------------------------------
module scancode_line_editor_unit
	import sle_pkg::*;
#(
	parameter int TEXT_MAX = 63,
	parameter int KEYMAP_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sle_req_if.sink               req_ch,
	sle_rsp_if.source             rsp_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	logic [RD_W-1:0]   repeat_delay_q;
	km_req_t           km_req;
	tx_req_t           tx_req;
	logic [CHAR_W-1:0] km_rdata;
	logic [CHAR_W-1:0] tx_rdata;
	logic              reg_hit;

	assign pready = 1'b1;
	assign reg_hit = (paddr[REG_ADDR_W-1] == REG_IDX_REPEAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q <= REPEAT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			repeat_delay_q <= pwdata[RD_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(32 - RD_W){1'b0}}, repeat_delay_q} : '0;

	sle_ctrl #(.TEXT_MAX(TEXT_MAX)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.repeat_delay(repeat_delay_q),
		.req(req_ch),
		.rsp(rsp_ch),
		.km_req(km_req),
		.km_rdata(km_rdata),
		.tx_req(tx_req),
		.tx_rdata(tx_rdata)
	);

	sle_keymap #(.KEYMAP_DEPTH(KEYMAP_DEPTH)) u_keymap (
		.clk(clk),
		.arst_n(arst_n),
		.req(km_req),
		.rdata(km_rdata)
	);

	sle_text_ram #(.TEXT_MAX(TEXT_MAX)) u_text (
		.clk(clk),
		.req(tx_req),
		.rdata(tx_rdata)
	);
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Line editor testbench: a local key and line model predicts every result
// item; directed edits, a full-line fill and random poll and map phases with idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import sle_pkg::*;

	localparam int LINE_MAX   = 63;
	localparam int CYCLE_CAP  = 2000000;
	localparam int SETTLE_CYC = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sle_req_if req_ch ();
	sle_rsp_if rsp_ch ();

	scancode_line_editor_unit dut (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .rsp_ch(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// model state
	logic [CHAR_W-1:0] key_table [128];
	logic [CHAR_W-1:0] line_buf [LINE_MAX];
	logic [CODE_W-1:0] good_code, held_code;
	logic [HOLD_W-1:0] hold_cnt;
	logic              shift_on;
	logic [RD_W-1:0]   rep_delay;
	logic [LEN_W-1:0]  line_len;
	logic [CUR_W-1:0]  cur_pos;

	res_t expected_items [$];
	int   fail_cnt = 0;
	int   cycle_cnt = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic [CODE_W-1:0] last_sent_code = '0;

	initial begin
		for (int i = 0; i < 128; i++) key_table[i] = '0;
		good_code = '0; held_code = '0; hold_cnt = '0; shift_on = 1'b0;
		rep_delay = REPEAT_RESET; line_len = '0; cur_pos = '0;
	end

	function automatic void push_res(kind_t k, logic [CHAR_W-1:0] ch,
			logic [CUR_W-1:0] cu, logic [LEN_W-1:0] ln, logic lst);
		res_t r;
		r.kind = k; r.char_value = ch; r.cursor = cu; r.line_length = ln; r.last = lst;
		expected_items.push_back(r);
	endfunction

	function automatic void push_now(kind_t k, logic [CHAR_W-1:0] ch);
		push_res(k, ch, cur_pos, line_len, 1'b1);
	endfunction

	function automatic void clear_line_state();
		good_code = '0; held_code = '0; hold_cnt = '0; shift_on = 1'b0;
		line_len = '0; cur_pos = '0;
	endfunction

	function automatic void flush_line(bit with_nl);
		int total;
		total = int'(line_len) + (with_nl ? 1 : 0);
		if (total == 0) begin
			push_res(K_EMPTY, '0, '0, '0, 1'b1);
		end else begin
			for (int i = 0; i < int'(line_len); i++)
				push_res(K_LINECH, line_buf[i], '0, LEN_W'(total), (i + 1 == total));
			if (with_nl) push_res(K_LINECH, CHAR_NEWLINE, '0, LEN_W'(total), 1'b1);
		end
		clear_line_state();
	endfunction

	function automatic void drop_at_cursor();
		for (int i = int'(cur_pos); i + 1 < int'(line_len); i++) line_buf[i] = line_buf[i + 1];
		line_len--;
	endfunction

	function automatic void predict_poll(logic [CODE_W-1:0] raw);
		logic [CODE_W-1:0] sc;
		logic [CHAR_W-1:0] ch;
		if (raw == CODE_RESEND || raw == '0) sc = good_code;
		else begin
			sc = raw;
			good_code = raw;
		end
		if (sc != held_code) hold_cnt = '0;
		else hold_cnt = (hold_cnt >= HOLD_TOP) ? HOLD_W'(HOLD_TOP - 5'd1)
			: HOLD_W'(hold_cnt + 5'd1);
		held_code = sc;
		if (sc == CODE_ENTER) begin
			flush_line(1);
			return;
		end
		if (hold_cnt[0] || (hold_cnt != 0 && hold_cnt < rep_delay)) begin
			push_now(K_IGNORE, '0);
		end else if (sc == CODE_LSHIFT || sc == CODE_RSHIFT) begin
			shift_on = 1'b1;
			push_now(K_IGNORE, '0);
		end else if (sc == CODE_LSHIFT_UP || sc == CODE_RSHIFT_UP) begin
			shift_on = 1'b0;
			push_now(K_IGNORE, '0);
		end else if (sc == CODE_LEFT) begin
			if (cur_pos == 0) push_now(K_IGNORE, '0);
			else begin
				cur_pos--;
				push_now(K_LEFT, '0);
			end
		end else if (sc == CODE_RIGHT) begin
			if (LEN_W'(cur_pos) >= line_len) push_now(K_IGNORE, '0);
			else begin
				cur_pos++;
				push_now(K_RIGHT, '0);
			end
		end else if (sc == CODE_BACK) begin
			if (cur_pos == 0) push_now(K_IGNORE, '0);
			else begin
				cur_pos--;
				drop_at_cursor();
				push_now(K_BACK, '0);
			end
		end else if (sc == CODE_DEL) begin
			if (LEN_W'(cur_pos) >= line_len) push_now(K_IGNORE, '0);
			else begin
				drop_at_cursor();
				push_now(K_DELETE, '0);
			end
		end else if (sc == CODE_ESC) begin
			flush_line(0);
		end else if (sc <= CODE_MAPMAX) begin
			ch = key_table[{sc[5:0], shift_on}];
			if (ch == '0) push_now(K_IGNORE, '0);
			else if (line_len >= LINE_MAX) push_now(K_FULL, ch);
			else begin
				for (int i = int'(line_len); i > int'(cur_pos); i--) line_buf[i] = line_buf[i - 1];
				line_buf[cur_pos] = ch;
				cur_pos++;
				line_len++;
				push_now(K_INSERT, ch);
			end
		end else begin
			push_now(K_IGNORE, '0);
		end
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_item(logic rtype, logic [KIDX_W-1:0] idx,
			logic [CHAR_W-1:0] ch, logic [CODE_W-1:0] sc);
		req_ch.valid = 1'b1;
		req_ch.req_type = rtype;
		req_ch.map_index = idx;
		req_ch.map_char = ch;
		req_ch.scancode = sc;
		do @(posedge clk); while (!req_ch.ready);
		if (rtype == 1'b0) begin
			key_table[idx] = ch;
			push_now(K_MAPWR, ch);
		end else begin
			predict_poll(sc);
		end
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	task automatic send_map(int idx, int ch);
		send_item(1'b0, KIDX_W'(idx), CHAR_W'(ch), CODE_W'($urandom_range(255)));
	endtask

	task automatic send_poll(int sc);
		send_item(1'b1, KIDX_W'($urandom_range(127)), CHAR_W'($urandom_range(255)),
			CODE_W'(sc));
		last_sent_code = CODE_W'(sc);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (expected_items.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] val);
		wait_drained();
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = REG_ADDR_W'(4 * idx); pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		if (idx == int'(REG_IDX_REPEAT)) rep_delay = val[RD_W-1:0];
	endtask

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		res_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_items.size() == 0) begin
				$error("result item with nothing expected, kind %0d", rsp_ch.kind);
				fail_cnt++;
			end else begin
				want = expected_items.pop_front();
				if (rsp_ch.kind != want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, rsp_ch.kind);
					fail_cnt++;
				end
				if (rsp_ch.char_value != want.char_value) begin
					$error("char_value: expected %0d actual %0d", want.char_value,
						rsp_ch.char_value);
					fail_cnt++;
				end
				if (rsp_ch.cursor != want.cursor) begin
					$error("cursor: expected %0d actual %0d", want.cursor, rsp_ch.cursor);
					fail_cnt++;
				end
				if (rsp_ch.line_length != want.line_length) begin
					$error("line_length: expected %0d actual %0d", want.line_length,
						rsp_ch.line_length);
					fail_cnt++;
				end
				if (rsp_ch.last != want.last) begin
					$error("last: expected %0d actual %0d", want.last, rsp_ch.last);
					fail_cnt++;
				end
			end
		end
	end

	task automatic test_directed_edits();
		send_map(127, 255);
		send_map(0, 0);
		send_map(4, 97);
		send_map(5, 65);
		send_map(6, 49);
		send_poll(2);
		send_poll(3);
		send_poll(CODE_LSHIFT);
		send_poll(2);
		send_poll(CODE_LSHIFT_UP);
		send_poll(2);
		send_poll(CODE_RESEND);  // last good code again: odd tick, ignored
		send_poll(CODE_LEFT);
		send_poll(CODE_RIGHT);
		send_poll(CODE_RIGHT);   // held key, ignored
		send_poll(CODE_LEFT);
		send_poll(CODE_BACK);
		send_poll(CODE_DEL);
		send_poll(10);           // mapped range, empty entry
		send_poll(58);           // above the mapped range
		send_poll(0);
		send_poll(CODE_ESC);
		send_poll(CODE_ESC);     // empty line
		send_poll(CODE_ENTER);   // newline only
	endtask

	task automatic test_full_line();
		send_poll(CODE_RSHIFT);
		send_poll(CODE_RSHIFT_UP);
		for (int i = 0; i < LINE_MAX + 1; i++) send_poll((i % 2) ? 3 : 2);
		send_poll(CODE_BACK);
		send_poll(CODE_LEFT);
		send_poll(CODE_BACK);
		send_poll(2);
		send_poll(CODE_ENTER);
	endtask

	function automatic int pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 38) return $urandom_range(57, 2);
		if (r < 56) return last_sent_code;
		if (r < 62) return $urandom_range(1) ? CODE_RESEND : 0;
		if (r < 68) begin
			case ($urandom_range(3))
				0: return CODE_LSHIFT;
				1: return CODE_RSHIFT;
				2: return CODE_LSHIFT_UP;
				default: return CODE_RSHIFT_UP;
			endcase
		end
		if (r < 82) begin
			case ($urandom_range(3))
				0: return CODE_LEFT;
				1: return CODE_RIGHT;
				2: return CODE_BACK;
				default: return CODE_DEL;
			endcase
		end
		if (r < 86) return CODE_ENTER;
		if (r < 88) return CODE_ESC;
		return $urandom_range(255);
	endfunction

	task automatic test_random_phase(int idle, int stall, int n, bit mid_drain);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (mid_drain && i == n / 2) wait_drained();
			if ($urandom_range(99) < 10) begin
				if ($urandom_range(3) == 0) send_map($urandom_range(127), $urandom_range(255));
				else send_map($urandom_range(115, 4), $urandom_range(255, 1));
			end else begin
				send_poll(pick_code());
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.map_index = '0;
		req_ch.map_char = '0;
		req_ch.scancode = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_edits();
		write_reg(int'(REG_IDX_REPEAT), 32'd1);
		test_full_line();
		for (int i = 0; i < 20; i++) send_map($urandom_range(115, 4), $urandom_range(255, 1));
		test_random_phase(0, 0, 80, 0);
		write_reg(int'(REG_IDX_REPEAT), 32'd16);
		test_random_phase(49, 0, 80, 1);
		write_reg(int'(REG_IDX_REPEAT), 32'd2);
		write_reg(1, 32'd7);     // unused register index
		test_random_phase(0, 49, 80, 0);
		write_reg(int'(REG_IDX_REPEAT), 32'd0);
		test_random_phase(15, 15, 35, 0);
		write_reg(int'(REG_IDX_REPEAT), 32'd31);
		test_random_phase(15, 15, 35, 0);

		send_idle_pct = 0;
		wait_drained();
		if (fail_cnt == 0 && expected_items.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/sle_pkg.sv
rtl/sle_if.sv
rtl/sle_keymap.sv
rtl/sle_text_ram.sv
rtl/sle_ctrl.sv
rtl/scancode_line_editor_unit.sv
dv/tb_top.sv
